// ===== sv/iirdf1_pkg.sv =====
package iirdf1_pkg;

    // field and storage widths
    localparam int unsigned SAMPLE_W   = 32;
    localparam int unsigned COEFF_W    = 16;
    localparam int unsigned ORDER_W    = 3;
    localparam int unsigned TAP_W      = 3;
    localparam int unsigned HIST_DEPTH = 8;
    localparam int unsigned MAX_ORDER  = 7;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CMD_W      = 2;

    // product Q20.28, accumulator holds at most 15 products of magnitude 2^46
    localparam int unsigned PROD_W     = COEFF_W + SAMPLE_W;
    localparam int unsigned ACC_W      = 51;
    // dividend (magnitude plus half divisor), padded to an even bit count
    localparam int unsigned NUM_W      = 52;
    localparam int unsigned DIV_STEPS  = NUM_W / 2;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    // item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_FILTER = 2'd0,
        CMD_SHIFT  = 2'd1,
        CMD_SET    = 2'd2,
        CMD_NOP    = 2'd3
    } command_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B_LO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_HI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A_HI  = 3'd4;

    // register reset values
    localparam logic [ORDER_W-1:0]    ORDER_RESET = 3'd1;
    localparam logic [CFG_DATA_W-1:0] A_LO_RESET  = 64'd4096;

    // controller to datapath commands
    typedef struct packed {
        logic             load_item;
        logic             push_in;
        logic             acc_clear;
        logic             mac_issue;
        logic             mac_phase_a;
        logic [TAP_W-1:0] tap;
        logic             div_load;
        logic             div_step;
        logic             finish;
        logic             apply_shift;
        logic             apply_set;
        logic             load_out;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [ORDER_W-1:0] order;
    } dp_status_t;

endpackage

// ===== sv/iirdf1_ctrl.sv =====
module iirdf1_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_valid,
    input  iirdf1_pkg::command_t  s_command,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  cfg_ready,
    input  iirdf1_pkg::dp_status_t status,
    output iirdf1_pkg::dp_cmd_t   cmd
);

    typedef enum logic [9:0] {
        S_IDLE        = 10'b0000000001,
        S_PUSH        = 10'b0000000010,
        S_MAC         = 10'b0000000100,
        S_DRAIN       = 10'b0000001000,
        S_DIVPREP     = 10'b0000010000,
        S_DIV         = 10'b0000100000,
        S_FIN         = 10'b0001000000,
        S_APPLY_SHIFT = 10'b0010000000,
        S_APPLY_SET   = 10'b0100000000,
        S_OUT         = 10'b1000000000
    } state_t;

    state_t                               state_reg, state_next;
    logic [iirdf1_pkg::TAP_W-1:0]         tap_reg, tap_next;
    logic                                 phase_a_reg, phase_a_next;
    logic [iirdf1_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                                 m_valid_reg, m_valid_next;

    // next state and command decode
    always_comb
    begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        phase_a_next = phase_a_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.tap      = tap_reg;
        cmd.mac_phase_a = phase_a_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.load_item = 1'b1;
                    case (s_command)
                        iirdf1_pkg::CMD_FILTER: state_next = S_PUSH;
                        iirdf1_pkg::CMD_SHIFT:  state_next = S_APPLY_SHIFT;
                        iirdf1_pkg::CMD_SET:    state_next = S_APPLY_SET;
                        default:                state_next = S_OUT;
                    endcase
                end
            end
            S_PUSH:
            begin
                cmd.push_in   = 1'b1;
                cmd.acc_clear = 1'b1;
                tap_next      = '0;
                phase_a_next  = 1'b0;
                state_next    = S_MAC;
            end
            S_MAC:
            begin
                // numerator taps 0..N, then denominator taps 1..N
                cmd.mac_issue = 1'b1;
                if (tap_reg == status.order)
                begin
                    if (phase_a_reg || (status.order == '0))
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        phase_a_next = 1'b1;
                        tap_next     = iirdf1_pkg::TAP_W'(1);
                    end
                end
                else
                begin
                    tap_next = tap_reg + iirdf1_pkg::TAP_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_DIVPREP;
            end
            S_DIVPREP:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == iirdf1_pkg::DIV_CNT_W'(iirdf1_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + iirdf1_pkg::DIV_CNT_W'(1);
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_APPLY_SHIFT:
            begin
                cmd.apply_shift = 1'b1;
                state_next      = S_OUT;
            end
            S_APPLY_SET:
            begin
                cmd.apply_set = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output beat valid
    always_comb
    begin
        m_valid_next = m_valid_reg & ~m_ready;
        if (cmd.load_out)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            tap_reg     <= '0;
            phase_a_reg <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            phase_a_reg <= phase_a_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;

endmodule

// ===== sv/iirdf1_dp.sv =====
module iirdf1_dp #(
    parameter int unsigned MAX_ORDER = iirdf1_pkg::MAX_ORDER
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  iirdf1_pkg::dp_cmd_t                   cmd,
    output iirdf1_pkg::dp_status_t                status,
    input  logic [iirdf1_pkg::SAMPLE_W-1:0]       s_value,
    input  logic                                  cfg_we,
    input  logic [iirdf1_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iirdf1_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [iirdf1_pkg::SAMPLE_W-1:0]       out_data,
    output logic                                  out_sat
);

    localparam int unsigned SW = iirdf1_pkg::SAMPLE_W;
    localparam int unsigned CW = iirdf1_pkg::COEFF_W;
    localparam int unsigned PW = iirdf1_pkg::PROD_W;
    localparam int unsigned AW = iirdf1_pkg::ACC_W;
    localparam int unsigned NW = iirdf1_pkg::NUM_W;
    localparam int unsigned HD = iirdf1_pkg::HIST_DEPTH;

    localparam logic [SW-1:0] Q_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] Q_MIN = {1'b1, {(SW-1){1'b0}}};

    // pick one Q4.12 coefficient out of a lo/hi register pair
    function automatic logic [CW-1:0] get_coeff(
        input logic [iirdf1_pkg::CFG_DATA_W-1:0] lo,
        input logic [iirdf1_pkg::CFG_DATA_W-1:0] hi,
        input logic [iirdf1_pkg::TAP_W-1:0]      idx
    );
        logic [iirdf1_pkg::CFG_DATA_W-1:0] word;
        word = idx[2] ? hi : lo;
        return word[{idx[1:0], 4'b0000} +: CW];
    endfunction

    logic [iirdf1_pkg::ORDER_W-1:0]    order_reg;
    logic [iirdf1_pkg::CFG_DATA_W-1:0] b_lo_reg, b_hi_reg, a_lo_reg, a_hi_reg;
    logic [SW-1:0]                     in_hist_reg [HD];
    logic [SW-1:0]                     out_hist_reg [HD];
    logic                              sat_reg;
    logic [SW-1:0]                     value_reg;
    logic signed [PW-1:0]              prod_reg;
    logic                              prod_sub_reg;
    logic                              prod_vld_reg;
    logic signed [AW-1:0]              acc_reg;
    logic [CW-1:0]                     div_reg;
    logic [CW-1:0]                     rem_reg;
    logic [NW-1:0]                     quo_reg;
    logic                              neg_reg;
    logic [SW-1:0]                     out_data_reg;
    logic                              out_sat_reg;

    // clamp order to the supported maximum
    always_comb
    begin
        if (order_reg > iirdf1_pkg::ORDER_W'(MAX_ORDER))
        begin
            status.order = iirdf1_pkg::ORDER_W'(MAX_ORDER);
        end
        else
        begin
            status.order = order_reg;
        end
    end

    // tap operand select and multiply
    logic signed [CW-1:0] coeff_sel;
    logic signed [SW-1:0] hist_sel;
    logic signed [PW-1:0] prod_next;
    logic [iirdf1_pkg::TAP_W-1:0] tap_prev;

    always_comb
    begin
        tap_prev = cmd.tap - iirdf1_pkg::TAP_W'(1);
        if (cmd.mac_phase_a)
        begin
            coeff_sel = get_coeff(a_lo_reg, a_hi_reg, cmd.tap);
            hist_sel  = out_hist_reg[tap_prev];
        end
        else
        begin
            coeff_sel = get_coeff(b_lo_reg, b_hi_reg, cmd.tap);
            hist_sel  = in_hist_reg[cmd.tap];
        end
        prod_next = coeff_sel * hist_sel;
    end

    // divisor and dividend preparation
    logic signed [CW-1:0] a0;
    logic                 a0_zero;
    logic                 acc_neg;
    logic                 acc_zero;
    logic [AW-1:0]        acc_mag;
    logic [CW-1:0]        div_abs;
    logic [NW-1:0]        num_init;

    always_comb
    begin
        a0       = get_coeff(a_lo_reg, a_hi_reg, '0);
        a0_zero  = (a0 == '0);
        acc_neg  = acc_reg[AW-1];
        acc_zero = (acc_reg == '0);
        acc_mag  = acc_neg ? AW'(-acc_reg) : AW'(acc_reg);
        div_abs  = a0[CW-1] ? CW'(-a0) : CW'(a0);
        num_init = NW'(acc_mag) + NW'(div_abs >> 1);
    end

    // two restoring division steps per cycle
    logic [CW:0]   trial1, trial2;
    logic          ge1, ge2;
    logic [CW-1:0] rem1, rem2;

    always_comb
    begin
        trial1 = {rem_reg, quo_reg[NW-1]};
        ge1    = (trial1 >= {1'b0, div_reg});
        rem1   = ge1 ? CW'(trial1 - {1'b0, div_reg}) : CW'(trial1);
        trial2 = {rem1, quo_reg[NW-2]};
        ge2    = (trial2 >= {1'b0, div_reg});
        rem2   = ge2 ? CW'(trial2 - {1'b0, div_reg}) : CW'(trial2);
    end

    // signed result with saturation
    logic [SW-1:0] fin_y;
    logic          fin_sat;
    logic          big_pos, big_neg;

    always_comb
    begin
        big_pos = |quo_reg[NW-1:SW-1];
        big_neg = (|quo_reg[NW-1:SW]) || (quo_reg[SW-1] && (|quo_reg[SW-2:0]));
        fin_sat = 1'b0;
        if (a0_zero)
        begin
            fin_sat = 1'b1;
            if (acc_neg)
            begin
                fin_y = Q_MIN;
            end
            else if (!acc_zero)
            begin
                fin_y = Q_MAX;
            end
            else
            begin
                fin_y = '0;
            end
        end
        else if (!neg_reg)
        begin
            fin_sat = big_pos;
            fin_y   = big_pos ? Q_MAX : quo_reg[SW-1:0];
        end
        else
        begin
            fin_sat = big_neg;
            fin_y   = big_neg ? Q_MIN : SW'(-quo_reg[SW-1:0]);
        end
    end

    // saturating add of the shift amount to every history entry
    logic [SW-1:0] shift_in [HD];
    logic [SW-1:0] shift_out [HD];
    logic [HD-1:0] clamp_in, clamp_out;
    logic [SW:0]   sum_in, sum_out;

    always_comb
    begin
        sum_in  = '0;
        sum_out = '0;
        for (int i = 0; i < HD; i++)
        begin
            sum_in  = {in_hist_reg[i][SW-1], in_hist_reg[i]} + {value_reg[SW-1], value_reg};
            sum_out = {out_hist_reg[i][SW-1], out_hist_reg[i]} + {value_reg[SW-1], value_reg};
            clamp_in[i]  = (sum_in[SW] != sum_in[SW-1]);
            clamp_out[i] = (sum_out[SW] != sum_out[SW-1]);
            shift_in[i]  = clamp_in[i] ? (sum_in[SW] ? Q_MIN : Q_MAX) : sum_in[SW-1:0];
            shift_out[i] = clamp_out[i] ? (sum_out[SW] ? Q_MIN : Q_MAX) : sum_out[SW-1:0];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= iirdf1_pkg::ORDER_RESET;
            b_lo_reg  <= '0;
            b_hi_reg  <= '0;
            a_lo_reg  <= iirdf1_pkg::A_LO_RESET;
            a_hi_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                iirdf1_pkg::REG_ORDER: order_reg <= cfg_data[iirdf1_pkg::ORDER_W-1:0];
                iirdf1_pkg::REG_B_LO:  b_lo_reg  <= cfg_data;
                iirdf1_pkg::REG_B_HI:  b_hi_reg  <= cfg_data;
                iirdf1_pkg::REG_A_LO:  a_lo_reg  <= cfg_data;
                iirdf1_pkg::REG_A_HI:  a_hi_reg  <= cfg_data;
                default:               ;
            endcase
        end
    end

    // input and output histories, entry 0 newest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HD; i++)
            begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index == iirdf1_pkg::REG_ORDER))
        begin
            for (int i = 0; i < HD; i++)
            begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end
        else if (cmd.push_in)
        begin
            for (int i = HD - 1; i > 0; i--)
            begin
                in_hist_reg[i] <= in_hist_reg[i-1];
            end
            in_hist_reg[0] <= value_reg;
        end
        else if (cmd.finish)
        begin
            for (int i = HD - 1; i > 0; i--)
            begin
                out_hist_reg[i] <= out_hist_reg[i-1];
            end
            out_hist_reg[0] <= fin_y;
        end
        else if (cmd.apply_shift)
        begin
            for (int i = 0; i < HD; i++)
            begin
                in_hist_reg[i]  <= shift_in[i];
                out_hist_reg[i] <= shift_out[i];
            end
        end
        else if (cmd.apply_set)
        begin
            for (int i = 0; i < HD; i++)
            begin
                in_hist_reg[i]  <= value_reg;
                out_hist_reg[i] <= value_reg;
            end
        end
    end

    // step flags and product valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg      <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mac_issue;
            if (cmd.load_item)
            begin
                sat_reg <= 1'b0;
            end
            else if (cmd.finish)
            begin
                sat_reg <= fin_sat;
            end
            else if (cmd.apply_shift)
            begin
                sat_reg <= (|clamp_in) | (|clamp_out);
            end
        end
    end

    // item, multiply-accumulate and divider payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            value_reg <= s_value;
        end
        if (cmd.mac_issue)
        begin
            prod_reg     <= prod_next;
            prod_sub_reg <= cmd.mac_phase_a;
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            if (prod_sub_reg)
            begin
                acc_reg <= acc_reg - AW'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + AW'(prod_reg);
            end
        end
        if (cmd.div_load)
        begin
            quo_reg <= num_init;
            rem_reg <= '0;
            div_reg <= div_abs;
            neg_reg <= acc_neg ^ a0[CW-1];
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[NW-3:0], ge1, ge2};
            rem_reg <= rem2;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= out_hist_reg[0];
            out_sat_reg  <= sat_reg;
        end
    end

    assign out_data = out_data_reg;
    assign out_sat  = out_sat_reg;

endmodule

// ===== sv/iir_direct_form_one_filter.sv =====
// Direct form I IIR filter, Q16.16 samples, Q4.12 coefficients, order 0..7.
// Input stream: s_axis_tdata carries the sample, shift amount or fill value,
// s_axis_tuser the command (filter, shift histories, set histories, no-op).
// Output stream: one beat per input beat, the newest output history entry on
// m_axis_tdata and a saturation flag on m_axis_tuser.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 order, 1..2 numerator
// and 3..4 denominator coefficients; writing the order clears both histories.
// A filter beat runs one multiply-accumulate per tap through a single
// multiplier, then a radix-4 restoring divide by a0. One item is worked on
// at a time; the next beat is taken the cycle after the result enters the
// output register.
// The output register holds a result while the receiver stalls; the next
// item is worked on meanwhile but its result waits until the register frees.
// Reset clears both histories and loads order 1, a0 = 1.0 and all other
// coefficients zero; no beat is pending after reset.
module iir_direct_form_one_filter #(
    parameter int unsigned MAX_ORDER = iirdf1_pkg::MAX_ORDER
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] filtered
    output logic [0:0]  m_axis_tuser,   // [0] saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    iirdf1_pkg::dp_cmd_t    dp_cmd;
    iirdf1_pkg::dp_status_t dp_status;
    iirdf1_pkg::command_t   s_command;
    logic                   out_sat;

    assign s_command = iirdf1_pkg::command_t'(s_axis_tuser);

    // sequencing
    iirdf1_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_command (s_command),
        .s_ready   (s_axis_tready),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .cfg_ready (cfg_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // histories, multiply-accumulate, divider and output register
    iirdf1_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .s_value   (s_axis_tdata),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata),
        .out_sat   (out_sat)
    );

    assign m_axis_tuser[0] = out_sat;

endmodule

// ===== verif/tb_iir_direct_form_one_filter.sv =====
module tb_iir_direct_form_one_filter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 60;
    localparam int unsigned RANDOM_PHASES  = 11;
    localparam int unsigned BEATS_PER_PHASE = 48;
    localparam int unsigned REG_COUNT      = 8;

    localparam logic [31:0] Q_MAX_WORD = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN_WORD = 32'h8000_0000;
    localparam logic [15:0] COEFF_ONE  = 16'h1000;

    typedef struct {
        iirdf1_pkg::command_t cmd;
        logic [31:0]          value;
    } sample_beat_t;

    typedef struct {
        logic [31:0] filtered;
        logic        saturated;
    } filter_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] value
    logic [1:0]  s_axis_tuser = iirdf1_pkg::CMD_NOP;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] filtered
    logic [0:0]  m_axis_tuser;        // [0] saturated
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [iirdf1_pkg::CFG_IDX_W-1:0]  cfg_index = iirdf1_pkg::REG_ORDER;
    logic [iirdf1_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // model state and register copies
    logic [iirdf1_pkg::ORDER_W-1:0]    mdl_order;
    logic [iirdf1_pkg::CFG_DATA_W-1:0] mdl_b_lo, mdl_b_hi, mdl_a_lo, mdl_a_hi;
    logic signed [31:0]    hist_x [iirdf1_pkg::HIST_DEPTH];
    logic signed [31:0]    hist_y [iirdf1_pkg::HIST_DEPTH];

    sample_beat_t   pending_samples [$];
    filter_result_t expected_outputs [$];

    int unsigned err_count = 0;
    int unsigned in_gap = 0;
    int unsigned out_stall = 0;
    bit          in_taken = 1'b0;
    bit          idle_enabled = 1'b1;
    int unsigned quiet_cycles = 0;
    int unsigned cmd_counts [4] = '{0, 0, 0, 0};
    int unsigned sat_results = 0;
    int unsigned settings_count = 0;

    iir_direct_form_one_filter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // signed Q4.12 tap k out of a lo/hi register pair
    function automatic longint tap_coeff(input logic [63:0] lo, input logic [63:0] hi,
                                         input int unsigned k);
        logic [63:0]        w;
        logic signed [15:0] c;
        begin
            w = (k < 4) ? lo : hi;
            c = w[16*(k%4) +: 16];
            return longint'(c);
        end
    endfunction

    function automatic logic [31:0] clamp_q(input longint v, inout bit sat);
        begin
            if (v > longint'(32'sh7FFF_FFFF))
            begin
                sat = 1'b1;
                return Q_MAX_WORD;
            end
            if (v < -longint'(32'sh7FFF_FFFF) - 1)
            begin
                sat = 1'b1;
                return Q_MIN_WORD;
            end
            return v[31:0];
        end
    endfunction

    // one direct form I output: numerator taps minus feedback taps, over a0
    function automatic logic [31:0] filter_output(input logic [31:0] x, inout bit sat);
        int unsigned        n;
        longint             acc;
        longint             a0;
        longint unsigned    mag, dv, q;
        bit                 neg;
        begin
            n = mdl_order;
            if (n > iirdf1_pkg::MAX_ORDER)
                n = iirdf1_pkg::MAX_ORDER;
            for (int k = iirdf1_pkg::HIST_DEPTH - 1; k > 0; k--)
                hist_x[k] = hist_x[k-1];
            hist_x[0] = x;
            acc = 0;
            for (int unsigned k = 0; k <= n; k++)
                acc += tap_coeff(mdl_b_lo, mdl_b_hi, k) * longint'(hist_x[k]);
            for (int unsigned k = 1; k <= n; k++)
                acc -= tap_coeff(mdl_a_lo, mdl_a_hi, k) * longint'(hist_y[k-1]);
            a0 = tap_coeff(mdl_a_lo, mdl_a_hi, 0);
            if (a0 == 0)
            begin
                sat = 1'b1;
                if (acc > 0)
                    return Q_MAX_WORD;
                if (acc < 0)
                    return Q_MIN_WORD;
                return '0;
            end
            // round half away from zero on magnitudes
            neg = (acc < 0) != (a0 < 0);
            mag = (acc < 0) ? longint'(-acc) : acc;
            dv  = (a0 < 0) ? longint'(-a0) : a0;
            q   = (mag + dv / 2) / dv;
            return clamp_q(neg ? -longint'(q) : longint'(q), sat);
        end
    endfunction

    // update the filter state for one accepted beat and queue its result
    task automatic predict_beat(input iirdf1_pkg::command_t cmd, input logic [31:0] value);
        bit             sat;
        longint         delta;
        filter_result_t res;
        logic [31:0]    y;
        begin
            sat = 1'b0;
            delta = longint'($signed(value));
            case (cmd)
                iirdf1_pkg::CMD_FILTER:
                begin
                    y = filter_output(value, sat);
                    for (int k = iirdf1_pkg::HIST_DEPTH - 1; k > 0; k--)
                        hist_y[k] = hist_y[k-1];
                    hist_y[0] = y;
                end
                iirdf1_pkg::CMD_SHIFT:
                    for (int k = 0; k < iirdf1_pkg::HIST_DEPTH; k++)
                    begin
                        hist_x[k] = clamp_q(longint'(hist_x[k]) + delta, sat);
                        hist_y[k] = clamp_q(longint'(hist_y[k]) + delta, sat);
                    end
                iirdf1_pkg::CMD_SET:
                    for (int k = 0; k < iirdf1_pkg::HIST_DEPTH; k++)
                    begin
                        hist_x[k] = value;
                        hist_y[k] = value;
                    end
                default: ;
            endcase
            res.filtered  = hist_y[0];
            res.saturated = sat;
            expected_outputs.push_back(res);
            cmd_counts[cmd]++;
            if (sat)
                sat_results++;
        end
    endtask

    task automatic clear_histories();
        begin
            for (int k = 0; k < iirdf1_pkg::HIST_DEPTH; k++)
            begin
                hist_x[k] = '0;
                hist_y[k] = '0;
            end
        end
    endtask

    task automatic apply_register(input logic [iirdf1_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [63:0] data);
        begin
            case (idx)
                iirdf1_pkg::REG_ORDER:
                begin
                    mdl_order = data[iirdf1_pkg::ORDER_W-1:0];
                    clear_histories();
                end
                iirdf1_pkg::REG_B_LO: mdl_b_lo = data;
                iirdf1_pkg::REG_B_HI: mdl_b_hi = data;
                iirdf1_pkg::REG_A_LO: mdl_a_lo = data;
                iirdf1_pkg::REG_A_HI: mdl_a_hi = data;
                default: ;
            endcase
        end
    endtask

    task automatic report_mismatch(input string msg);
        begin
            err_count++;
            $display("[%0t] mismatch %0d: %s", $realtime, err_count, msg);
        end
    endtask

    // gap length: mostly none or short, now and then long
    function automatic int unsigned next_gap();
        int unsigned r;
        begin
            if (!idle_enabled)
                return 0;
            r = $urandom_range(0, 99);
            if (r < 50)
                return 0;
            if (r < 85)
                return $urandom_range(1, 3);
            if (r < 97)
                return $urandom_range(4, 12);
            return $urandom_range(20, 60);
        end
    endfunction

    // input side: note accepted beats at the rising edge
    always @(posedge clk)
    begin
        in_taken = s_axis_tvalid && s_axis_tready;
        if (in_taken)
        begin
            predict_beat(iirdf1_pkg::command_t'(s_axis_tuser), s_axis_tdata);
            void'(pending_samples.pop_front());
            in_gap = next_gap();
        end
    end

    // input side: present the next beat at the falling edge
    always @(negedge clk)
    begin
        if (s_axis_tvalid && !in_taken)
        begin
            // hold the beat until it is taken
        end
        else if (in_gap != 0)
        begin
            in_gap--;
            s_axis_tvalid <= 1'b0;
        end
        else if (pending_samples.size() != 0)
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pending_samples[0].value;
            s_axis_tuser  <= pending_samples[0].cmd;
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // output side: random backpressure
    always @(negedge clk)
    begin
        if (out_stall != 0)
        begin
            out_stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                out_stall = next_gap();
        end
    end

    // output side: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : result_check
        filter_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_outputs.size() == 0)
                report_mismatch($sformatf("result beat %h/%b with no item outstanding",
                                          m_axis_tdata, m_axis_tuser));
            else
            begin
                want = expected_outputs.pop_front();
                if (m_axis_tdata !== want.filtered)
                    report_mismatch($sformatf("filtered %h, want %h",
                                              m_axis_tdata, want.filtered));
                if (m_axis_tuser[0] !== want.saturated)
                    report_mismatch($sformatf("saturated %b, want %b (filtered %h)",
                                              m_axis_tuser[0], want.saturated,
                                              want.filtered));
            end
        end
    end

    // watchdog on beats of any channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_outputs.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic write_reg(input logic [iirdf1_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            do
                @(posedge clk);
            while (!cfg_ready);
            apply_register(idx, data);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic send(input iirdf1_pkg::command_t cmd, input logic [31:0] value);
        sample_beat_t b;
        begin
            b.cmd   = cmd;
            b.value = value;
            pending_samples.push_back(b);
        end
    endtask

    task automatic wait_idle();
        begin
            while (pending_samples.size() != 0 || expected_outputs.size() != 0)
                @(posedge clk);
            @(negedge clk);
            settings_count++;
        end
    endtask

    function automatic logic [31:0] rand_value();
        int s;
        begin
            case ($urandom_range(0, 9))
                0:
                    case ($urandom_range(0, 4))
                        0: return Q_MAX_WORD;
                        1: return Q_MIN_WORD;
                        2: return '0;
                        3: return 32'hFFFF_FFFF;
                        default: return 32'h0001_0000;
                    endcase
                1, 2, 3:
                    return $urandom;
                default:
                begin
                    s = int'($urandom_range(0, 2097151)) - 1048576;
                    return 32'(s);
                end
            endcase
        end
    endfunction

    // four packed Q4.12 taps, either tame or fully random
    function automatic logic [63:0] rand_coeff_word(input bit wild);
        logic [63:0] w;
        int          c;
        begin
            if (wild)
                return {$urandom, $urandom};
            for (int k = 0; k < 4; k++)
            begin
                c = int'($urandom_range(0, 2047)) - 1024;
                w[16*k +: 16] = 16'(c);
            end
            return w;
        end
    endfunction

    task automatic random_phase(input bit first);
        int unsigned mode;
        int unsigned r;
        logic [63:0] a_lo;
        logic [15:0] a0;
        begin
            mode = $urandom_range(0, 9);
            idle_enabled = ($urandom_range(0, 3) != 0);
            if (first || $urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: write_reg(iirdf1_pkg::REG_ORDER, 64'(0));
                    1: write_reg(iirdf1_pkg::REG_ORDER, 64'(iirdf1_pkg::MAX_ORDER));
                    default: write_reg(iirdf1_pkg::REG_ORDER, 64'($urandom_range(0, 7)));
                endcase
            end
            write_reg(iirdf1_pkg::REG_B_LO, rand_coeff_word(mode >= 7));
            write_reg(iirdf1_pkg::REG_B_HI, rand_coeff_word(mode >= 7));
            a_lo = rand_coeff_word(mode >= 7);
            if (mode < 7)
            begin
                a0 = COEFF_ONE + 16'($urandom_range(0, 4095));
                if ($urandom_range(0, 4) == 0)
                    a0 = -a0;
                a_lo[15:0] = a0;
            end
            else if (mode == 9)
                a_lo[15:0] = '0;
            write_reg(iirdf1_pkg::REG_A_LO, a_lo);
            write_reg(iirdf1_pkg::REG_A_HI, rand_coeff_word(mode >= 7));
            @(negedge clk);
            for (int unsigned i = 0; i < BEATS_PER_PHASE; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    send(iirdf1_pkg::CMD_FILTER, rand_value());
                else if (r < 88)
                    send(iirdf1_pkg::CMD_SHIFT, rand_value());
                else if (r < 95)
                    send(iirdf1_pkg::CMD_SET, rand_value());
                else
                    send(iirdf1_pkg::CMD_NOP, rand_value());
            end
            wait_idle();
        end
    endtask

    // stimulus
    initial
    begin
        mdl_order = iirdf1_pkg::ORDER_RESET;
        mdl_b_lo  = '0;
        mdl_b_hi  = '0;
        mdl_a_lo  = iirdf1_pkg::A_LO_RESET;
        mdl_a_hi  = '0;
        clear_histories();

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: histories at the rails, shift overflow both ways, no-op
        idle_enabled = 1'b1;
        send(iirdf1_pkg::CMD_FILTER, Q_MAX_WORD);
        send(iirdf1_pkg::CMD_SET, Q_MAX_WORD);
        send(iirdf1_pkg::CMD_SHIFT, 32'h0000_0001);
        send(iirdf1_pkg::CMD_SHIFT, Q_MIN_WORD);
        send(iirdf1_pkg::CMD_SET, Q_MIN_WORD);
        send(iirdf1_pkg::CMD_SHIFT, 32'hFFFF_FFFF);
        send(iirdf1_pkg::CMD_NOP, 32'h1234_5678);
        wait_idle();

        // first order with feedback, driven into saturation
        write_reg(iirdf1_pkg::REG_ORDER, 64'(1));
        write_reg(iirdf1_pkg::REG_B_LO, {32'h0, 16'h0800, COEFF_ONE});
        write_reg(iirdf1_pkg::REG_A_LO, {32'h0, 16'hF800, COEFF_ONE});
        send(iirdf1_pkg::CMD_FILTER, Q_MAX_WORD);
        send(iirdf1_pkg::CMD_FILTER, Q_MAX_WORD);
        send(iirdf1_pkg::CMD_FILTER, Q_MIN_WORD);
        send(iirdf1_pkg::CMD_FILTER, Q_MIN_WORD);
        send(iirdf1_pkg::CMD_FILTER, '0);
        wait_idle();

        // zero a0: positive, zero and negative sums
        write_reg(iirdf1_pkg::REG_A_LO, '0);
        send(iirdf1_pkg::CMD_SET, '0);
        send(iirdf1_pkg::CMD_FILTER, 32'h0001_0000);
        send(iirdf1_pkg::CMD_SET, '0);
        send(iirdf1_pkg::CMD_FILTER, '0);
        send(iirdf1_pkg::CMD_FILTER, 32'hFFFF_0000);
        wait_idle();

        // order zero with the largest gain
        write_reg(iirdf1_pkg::REG_ORDER, 64'(0));
        write_reg(iirdf1_pkg::REG_B_LO, {48'h0, 16'h7FFF});
        write_reg(iirdf1_pkg::REG_A_LO, {48'h0, COEFF_ONE});
        send(iirdf1_pkg::CMD_FILTER, Q_MAX_WORD);
        send(iirdf1_pkg::CMD_FILTER, Q_MIN_WORD);
        send(iirdf1_pkg::CMD_FILTER, 32'h0000_0100);
        wait_idle();

        // rounding ties away from zero, positive and negative a0
        write_reg(iirdf1_pkg::REG_B_LO, {48'h0, 16'h0001});
        write_reg(iirdf1_pkg::REG_A_LO, {48'h0, 16'h0002});
        send(iirdf1_pkg::CMD_FILTER, 32'h0000_0001);
        send(iirdf1_pkg::CMD_FILTER, 32'hFFFF_FFFF);
        send(iirdf1_pkg::CMD_FILTER, 32'h0000_0003);
        wait_idle();
        write_reg(iirdf1_pkg::REG_A_LO, {48'h0, 16'hFFFE});
        send(iirdf1_pkg::CMD_FILTER, 32'h0000_0001);
        wait_idle();

        // full order with extreme upper taps; unused indexes are ignored
        write_reg(iirdf1_pkg::REG_ORDER, 64'(iirdf1_pkg::MAX_ORDER));
        write_reg(iirdf1_pkg::REG_B_LO, {4{16'h7FFF}});
        write_reg(iirdf1_pkg::REG_B_HI, {16'h8000, 48'h0});
        write_reg(iirdf1_pkg::REG_A_LO, {48'h0, COEFF_ONE});
        write_reg(iirdf1_pkg::REG_A_HI, {16'h7FFF, 48'h0});
        for (int r = iirdf1_pkg::REG_A_HI + 1; r < REG_COUNT; r++)
            write_reg(iirdf1_pkg::CFG_IDX_W'(r), {$urandom, $urandom});
        send(iirdf1_pkg::CMD_FILTER, Q_MAX_WORD);
        send(iirdf1_pkg::CMD_FILTER, Q_MIN_WORD);
        wait_idle();

        // random settings and traffic
        for (int unsigned p = 0; p < RANDOM_PHASES; p++)
            random_phase(p == 0);

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d filter, %0d shift, %0d set and %0d no-op beats",
                 cmd_counts[iirdf1_pkg::CMD_FILTER], cmd_counts[iirdf1_pkg::CMD_SHIFT],
                 cmd_counts[iirdf1_pkg::CMD_SET], cmd_counts[iirdf1_pkg::CMD_NOP]);
        $display("over %0d register settings, %0d results flagged saturated, %0d mismatches",
                 settings_count, sat_results, err_count);
        if (err_count == 0 && expected_outputs.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
sv/iirdf1_pkg.sv
sv/iirdf1_ctrl.sv
sv/iirdf1_dp.sv
sv/iir_direct_form_one_filter.sv
verif/tb_iir_direct_form_one_filter.sv
